>>> design/mts_pkg.sv
// ----------------------------------------------------------------------------
// mts_pkg
// Shared types and constants for the min-tracking stack.
// ----------------------------------------------------------------------------
package mts_pkg;

    localparam int unsigned DEF_DEPTH      = 128;
    localparam int unsigned DEF_DATA_WIDTH = 32;

    typedef enum logic [1:0] {
        CMD_PUSH  = 2'd0,
        CMD_POP   = 2'd1,
        CMD_QUERY = 2'd2
    } t_cmd;

    typedef struct packed {
        logic [1:0]         command;
        logic signed [31:0] push_value;
    } t_in_item;

    typedef struct packed {
        logic signed [31:0] popped_value;
        logic signed [31:0] top_value;
        logic signed [31:0] min_value;
        logic               is_empty;
        logic [7:0]         entry_count;
        logic               rejected;
    } t_out_item;

    typedef struct packed {
        logic exec;
        logic load_rd;
        logic emit;
    } t_dp_cmd;

    typedef struct packed {
        logic pop_go;
    } t_dp_status;

endpackage

>>> design/mts_ctrl.sv
// ----------------------------------------------------------------------------
// mts_ctrl
// Sequencer for the min-tracking stack: accepts transactions, waits for the
// memory read on a pop and hands results to the output register.
// ----------------------------------------------------------------------------
module mts_ctrl
    import mts_pkg::*;
(
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_in_valid,
    output logic       o_in_stall,
    output logic       o_out_valid,
    input  logic       i_out_stall,
    input  t_dp_status i_status,
    output t_dp_cmd    o_cmd
);

    typedef enum logic [2:0] {
        S_IDLE   = 3'b001,
        S_POP_RD = 3'b010,
        S_EMIT   = 3'b100
    } t_state;

    t_state r_state, n_state;
    logic   r_out_valid, n_out_valid;
    logic   slot_free;
    logic   emit_ok;
    logic   accept;

    assign slot_free  = !r_out_valid || !i_out_stall;
    assign emit_ok    = (r_state == S_EMIT) && slot_free;
    assign o_in_stall = !((r_state == S_IDLE) || emit_ok);
    assign accept     = i_in_valid && !o_in_stall;

    assign o_cmd.exec    = accept;
    assign o_cmd.load_rd = (r_state == S_POP_RD);
    assign o_cmd.emit    = emit_ok;
    assign o_out_valid   = r_out_valid;

    always_comb begin
        n_state = r_state;
        if (accept) begin
            n_state = i_status.pop_go ? S_POP_RD : S_EMIT;
        end else begin
            case (r_state)
                S_POP_RD: n_state = S_EMIT;
                S_EMIT:   n_state = emit_ok ? S_IDLE : S_EMIT;
                S_IDLE:   n_state = S_IDLE;
                default:  n_state = S_IDLE;
            endcase
        end
    end

    always_comb begin
        n_out_valid = r_out_valid;
        if (emit_ok) begin
            n_out_valid = 1'b1;
        end else if (!i_out_stall) begin
            n_out_valid = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_out_valid <= n_out_valid;
        end
    end

endmodule

>>> design/mts_datapath.sv
// ----------------------------------------------------------------------------
// mts_datapath
// Entry and running-minimum memories, registered top of stack, count and
// output register.
// ----------------------------------------------------------------------------
module mts_datapath
    import mts_pkg::*;
#(
    parameter int unsigned DEPTH      = DEF_DEPTH,
    parameter int unsigned DATA_WIDTH = DEF_DATA_WIDTH
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  t_in_item   i_in_data,
    input  t_dp_cmd    i_cmd,
    output t_dp_status o_status,
    output t_out_item  o_out_data
);

    localparam int unsigned AW = $clog2(DEPTH);
    localparam int unsigned CW = $clog2(DEPTH + 1);

    logic signed [DATA_WIDTH-1:0] ent_mem [DEPTH];
    logic signed [DATA_WIDTH-1:0] min_mem [DEPTH];

    logic [CW-1:0]                r_count, n_count;
    logic signed [DATA_WIDTH-1:0] r_top, n_top;
    logic signed [DATA_WIDTH-1:0] r_min, n_min;
    logic signed [31:0]           r_popped, n_popped;
    logic                         r_rej, n_rej;
    logic signed [DATA_WIDTH-1:0] r_rd_ent;
    logic signed [DATA_WIDTH-1:0] r_rd_min;
    t_out_item                    r_out;

    logic signed [DATA_WIDTH-1:0] push_word;
    logic signed [DATA_WIDTH-1:0] push_min;
    logic                         is_full;
    logic                         is_empty;
    logic                         push_go;
    logic                         wr_en;
    logic [CW-1:0]                rd_count;
    logic [AW-1:0]                wr_addr;
    logic [AW-1:0]                rd_addr;
    t_out_item                    res;

    assign is_full   = (r_count == CW'(DEPTH));
    assign is_empty  = (r_count == '0);
    assign push_word = DATA_WIDTH'(i_in_data.push_value);
    assign push_min  = (!is_empty && (r_min < push_word)) ? r_min : push_word;
    assign push_go   = (i_in_data.command == CMD_PUSH) && !is_full;
    assign wr_en     = i_cmd.exec && push_go;
    assign wr_addr   = r_count[AW-1:0];
    assign rd_count  = r_count - CW'(2);
    assign rd_addr   = rd_count[AW-1:0];

    assign o_status.pop_go = (i_in_data.command == CMD_POP) && !is_empty;

    always_comb begin
        n_count  = r_count;
        n_top    = r_top;
        n_min    = r_min;
        n_popped = r_popped;
        n_rej    = r_rej;
        if (i_cmd.exec) begin
            n_popped = '0;
            n_rej    = 1'b0;
            case (i_in_data.command)
                CMD_PUSH: begin
                    if (is_full) begin
                        n_rej = 1'b1;
                    end else begin
                        n_top   = push_word;
                        n_min   = push_min;
                        n_count = r_count + CW'(1);
                    end
                end
                CMD_POP: begin
                    if (is_empty) begin
                        n_rej = 1'b1;
                    end else begin
                        n_popped = 32'(r_top);
                        n_count  = r_count - CW'(1);
                    end
                end
                default: ;
            endcase
        end else if (i_cmd.load_rd) begin
            n_top = r_rd_ent;
            n_min = r_rd_min;
        end
    end

    always_comb begin
        res.popped_value = r_popped;
        res.top_value    = is_empty ? '0 : 32'(r_top);
        res.min_value    = is_empty ? '0 : 32'(r_min);
        res.is_empty     = is_empty;
        res.entry_count  = 8'(r_count);
        res.rejected     = r_rej;
    end

    always_ff @(posedge i_clk) begin
        if (wr_en) begin
            ent_mem[wr_addr] <= push_word;
            min_mem[wr_addr] <= push_min;
        end
        r_rd_ent <= ent_mem[rd_addr];
        r_rd_min <= min_mem[rd_addr];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count <= '0;
        end else begin
            r_count <= n_count;
        end
    end

    always_ff @(posedge i_clk) begin
        r_top    <= n_top;
        r_min    <= n_min;
        r_popped <= n_popped;
        r_rej    <= n_rej;
        if (i_cmd.emit) begin
            r_out <= res;
        end
    end

    assign o_out_data = r_out;

endmodule

>>> design/min_tracking_stack_core.sv
// ----------------------------------------------------------------------------
// min_tracking_stack_core
// Bounded stack of signed words that reports its smallest held value.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel i_in_valid / o_in_stall carries push, pop or query
//   transactions; output channel o_out_valid / i_out_stall returns exactly
//   one result transaction per input, in order.
//   Each entry is stored with the running minimum of itself and everything
//   below it; the top entry and its minimum sit in registers.
//   Push and query: the result is registered in the stack state, then in the
//   output register; a new transaction is taken every cycle while the output
//   register is free. Pop: the new top and minimum come from the synchronous
//   memory read ports via a read state, during which no input is taken.
//   The output register holds a result while the receiver stalls; the next
//   transaction may be accepted meanwhile, and is held once computed until
//   the output register frees up.
//   Reset (synchronous, active low) empties the stack and clears the output
//   valid; memory contents are not cleared and need no clearing pass.
// ----------------------------------------------------------------------------
module min_tracking_stack_core
    import mts_pkg::*;
#(
    parameter int unsigned DEPTH      = DEF_DEPTH,
    parameter int unsigned DATA_WIDTH = DEF_DATA_WIDTH
) (
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  logic      i_in_valid,
    output logic      o_in_stall,
    input  t_in_item  i_in_data,
    output logic      o_out_valid,
    input  logic      i_out_stall,
    output t_out_item o_out_data
);

    t_dp_cmd    cmd;
    t_dp_status status;

    mts_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_stall  (o_in_stall),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .i_status    (status),
        .o_cmd       (cmd)
    );

    mts_datapath #(
        .DEPTH      (DEPTH),
        .DATA_WIDTH (DATA_WIDTH)
    ) u_datapath (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_data  (i_in_data),
        .i_cmd      (cmd),
        .o_status   (status),
        .o_out_data (o_out_data)
    );

endmodule

>>> design/mts_checker.sv
// ----------------------------------------------------------------------------
// mts_checker
// Port-level checks for the min-tracking stack.
// ----------------------------------------------------------------------------
module mts_checker
    import mts_pkg::*;
(
    input logic      i_clk,
    input logic      i_rst_n,
    input logic      i_in_valid,
    input logic      o_in_stall,
    input t_in_item  i_in_data,
    input logic      o_out_valid,
    input logic      i_out_stall,
    input t_out_item o_out_data
);

    a_in_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_in_valid && o_in_stall |=> i_in_valid && $stable(i_in_data))
        else $error("stalled input transaction changed");

    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && i_out_stall |=> o_out_valid && $stable(o_out_data))
        else $error("stalled result transaction changed");

    a_empty_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_out_data.is_empty |->
            o_out_data.entry_count == 8'd0 && o_out_data.top_value == 32'sd0
            && o_out_data.min_value == 32'sd0)
        else $error("empty result with nonzero top, min or count");

    a_reject_no_pop: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_out_data.rejected |-> o_out_data.popped_value == 32'sd0)
        else $error("rejected transaction returned a popped value");

    a_min_le_top: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !o_out_data.is_empty |->
            o_out_data.min_value <= o_out_data.top_value)
        else $error("minimum exceeds top entry");

endmodule

bind min_tracking_stack_core mts_checker u_mts_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_in_valid  (i_in_valid),
    .o_in_stall  (o_in_stall),
    .i_in_data   (i_in_data),
    .o_out_valid (o_out_valid),
    .i_out_stall (i_out_stall),
    .o_out_data  (o_out_data)
);
